>>> sv/sth_pkg.sv
// ----------------------------------------------------------------------------
// sth_pkg
// shared constants for the segment / triangle hit test
// ----------------------------------------------------------------------------
package sth_pkg;

  // vectors are held as unpacked arrays of axes
  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned AXIS_X   = 0;
  localparam int unsigned AXIS_Y   = 1;
  localparam int unsigned AXIS_Z   = 2;

  // configuration register map
  localparam int unsigned CFG_IDX_WIDTH = 2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_VERTEX_A = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_VERTEX_B = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_VERTEX_C = 2'd2;

endpackage

>>> sv/sth_cross.sv
// ----------------------------------------------------------------------------
// sth_cross
// exact signed cross product of two small vectors, combinational
// ----------------------------------------------------------------------------
module sth_cross
  import sth_pkg::*;
#(
  parameter int unsigned IN_WIDTH = 17
) (
  input  logic signed [IN_WIDTH-1:0] p_i [NUM_AXES],
  input  logic signed [IN_WIDTH-1:0] q_i [NUM_AXES],
  output logic signed [2*IN_WIDTH:0] r_o [NUM_AXES]
);

  localparam int unsigned MW = 2 * IN_WIDTH;

  logic signed [MW-1:0] m_yz, m_zy, m_zx, m_xz, m_xy, m_yx;

  assign m_yz = MW'(p_i[AXIS_Y]) * MW'(q_i[AXIS_Z]);
  assign m_zy = MW'(p_i[AXIS_Z]) * MW'(q_i[AXIS_Y]);
  assign m_zx = MW'(p_i[AXIS_Z]) * MW'(q_i[AXIS_X]);
  assign m_xz = MW'(p_i[AXIS_X]) * MW'(q_i[AXIS_Z]);
  assign m_xy = MW'(p_i[AXIS_X]) * MW'(q_i[AXIS_Y]);
  assign m_yx = MW'(p_i[AXIS_Y]) * MW'(q_i[AXIS_X]);

  // one extra bit so the difference never wraps
  assign r_o[AXIS_X] = (MW+1)'(m_yz) - (MW+1)'(m_zy);
  assign r_o[AXIS_Y] = (MW+1)'(m_zx) - (MW+1)'(m_xz);
  assign r_o[AXIS_Z] = (MW+1)'(m_xy) - (MW+1)'(m_yx);

endmodule

>>> sv/segment_triangle_hit_test.sv
// stages in order: differences, cross products, terms, sums, sign test
// throughput: one segment per cycle while the output takes results, each stage
// holds its item on a stall; an empty stage fills even while the output waits
// the depth is set by the two multiply levels (cross, then dot products)
// reset clears every stage valid bit and puts all three vertices at the origin
// ----------------------------------------------------------------------------
// segment_triangle_hit_test
// exact, division-free test of a closed segment against a closed triangle
// ----------------------------------------------------------------------------
module segment_triangle_hit_test
  import sth_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_WIDTH-1:0]      cfg_index_i,
  input  logic [3*COORD_WIDTH-1:0]      cfg_wdata_i,
  // segment input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] start_z_i,
  input  logic signed [COORD_WIDTH-1:0] end_x_i,
  input  logic signed [COORD_WIDTH-1:0] end_y_i,
  input  logic signed [COORD_WIDTH-1:0] end_z_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;        // coordinate differences
  localparam int unsigned CW = 2 * DW + 1;   // cross products
  localparam int unsigned PW = DW + CW;      // dot product terms
  localparam int unsigned SW = PW + 2;       // dot product sums
  localparam int unsigned NUM_STAGES = 5;
  localparam int unsigned LAST = NUM_STAGES - 1;

  // --------------------------------------------------------------------------
  // configuration registers, the write port never stalls
  // --------------------------------------------------------------------------
  logic [3*W-1:0] vtx_a_q, vtx_b_q, vtx_c_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_a_q <= '0;
      vtx_b_q <= '0;
      vtx_c_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_VERTEX_A: vtx_a_q <= cfg_wdata_i;
        REG_VERTEX_B: vtx_b_q <= cfg_wdata_i;
        REG_VERTEX_C: vtx_c_q <= cfg_wdata_i;
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  // unpack the vertices into signed coordinates, x in the low bits
  logic signed [W-1:0] a_v [NUM_AXES];
  logic signed [W-1:0] b_v [NUM_AXES];
  logic signed [W-1:0] c_v [NUM_AXES];
  logic signed [W-1:0] s_v [NUM_AXES];
  logic signed [W-1:0] e_v [NUM_AXES];

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      a_v[k] = signed'(vtx_a_q[k*W +: W]);
      b_v[k] = signed'(vtx_b_q[k*W +: W]);
      c_v[k] = signed'(vtx_c_q[k*W +: W]);
    end
  end

  assign s_v[AXIS_X] = start_x_i;
  assign s_v[AXIS_Y] = start_y_i;
  assign s_v[AXIS_Z] = start_z_i;
  assign e_v[AXIS_X] = end_x_i;
  assign e_v[AXIS_Y] = end_y_i;
  assign e_v[AXIS_Z] = end_z_i;

  // --------------------------------------------------------------------------
  // pipeline control: each stage loads when it is empty or its successor
  // loads, so bubbles close up behind a stalled output
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] valid_d;
  logic [NUM_STAGES-1:0] rdy;

  always_comb begin
    rdy[LAST] = !valid_q[LAST] || out_ready_i;
    for (int i = LAST - 1; i >= 0; i--) begin
      rdy[i] = !valid_q[i] || rdy[i+1];
    end
  end

  always_comb begin
    valid_d[0] = rdy[0] ? in_valid_i : valid_q[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (rdy[i]) begin
        valid_d[i] = valid_q[i-1];
      end else begin
        valid_d[i] = valid_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[LAST];

  // --------------------------------------------------------------------------
  // stage 1: differences against the segment start and the triangle edges
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] d1_q  [NUM_AXES];  // end - start
  logic signed [DW-1:0] as1_q [NUM_AXES];  // a - start
  logic signed [DW-1:0] bs1_q [NUM_AXES];  // b - start
  logic signed [DW-1:0] cs1_q [NUM_AXES];  // c - start
  logic signed [DW-1:0] ba1_q [NUM_AXES];  // b - a
  logic signed [DW-1:0] ca1_q [NUM_AXES];  // c - a

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        d1_q[k]  <= DW'(e_v[k]) - DW'(s_v[k]);
        as1_q[k] <= DW'(a_v[k]) - DW'(s_v[k]);
        bs1_q[k] <= DW'(b_v[k]) - DW'(s_v[k]);
        cs1_q[k] <= DW'(c_v[k]) - DW'(s_v[k]);
        ba1_q[k] <= DW'(b_v[k]) - DW'(a_v[k]);
        ca1_q[k] <= DW'(c_v[k]) - DW'(a_v[k]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: triangle normal and the ab, bc and ca edge cross products
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] n_x   [NUM_AXES];
  logic signed [CW-1:0] xab_x [NUM_AXES];
  logic signed [CW-1:0] xbc_x [NUM_AXES];
  logic signed [CW-1:0] xca_x [NUM_AXES];

  sth_cross #(.IN_WIDTH(DW)) u_cross_n (
    .p_i(ba1_q), .q_i(ca1_q), .r_o(n_x)
  );
  sth_cross #(.IN_WIDTH(DW)) u_cross_ab (
    .p_i(as1_q), .q_i(bs1_q), .r_o(xab_x)
  );
  sth_cross #(.IN_WIDTH(DW)) u_cross_bc (
    .p_i(bs1_q), .q_i(cs1_q), .r_o(xbc_x)
  );
  sth_cross #(.IN_WIDTH(DW)) u_cross_ca (
    .p_i(cs1_q), .q_i(as1_q), .r_o(xca_x)
  );

  logic signed [DW-1:0] d2_q   [NUM_AXES];
  logic signed [DW-1:0] as2_q  [NUM_AXES];
  logic signed [CW-1:0] n2_q   [NUM_AXES];
  logic signed [CW-1:0] xab2_q [NUM_AXES];
  logic signed [CW-1:0] xbc2_q [NUM_AXES];
  logic signed [CW-1:0] xca2_q [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (rdy[1] && valid_q[0]) begin
      d2_q   <= d1_q;
      as2_q  <= as1_q;
      n2_q   <= n_x;
      xab2_q <= xab_x;
      xbc2_q <= xbc_x;
      xca2_q <= xca_x;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: per-axis terms of den, num and the ab, bc and ca edge volumes
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] pden3_q [NUM_AXES];
  logic signed [PW-1:0] pnum3_q [NUM_AXES];
  logic signed [PW-1:0] pab3_q  [NUM_AXES];
  logic signed [PW-1:0] pbc3_q  [NUM_AXES];
  logic signed [PW-1:0] pca3_q  [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (rdy[2] && valid_q[1]) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        pden3_q[k] <= PW'(d2_q[k])  * PW'(n2_q[k]);
        pnum3_q[k] <= PW'(as2_q[k]) * PW'(n2_q[k]);
        pab3_q[k]  <= PW'(d2_q[k])  * PW'(xab2_q[k]);
        pbc3_q[k]  <= PW'(d2_q[k])  * PW'(xbc2_q[k]);
        pca3_q[k]  <= PW'(d2_q[k])  * PW'(xca2_q[k]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: sum the terms
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] den4_q, num4_q, vab4_q, vbc4_q, vca4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3] && valid_q[2]) begin
      den4_q <= SW'(pden3_q[AXIS_X]) + SW'(pden3_q[AXIS_Y]) + SW'(pden3_q[AXIS_Z]);
      num4_q <= SW'(pnum3_q[AXIS_X]) + SW'(pnum3_q[AXIS_Y]) + SW'(pnum3_q[AXIS_Z]);
      vab4_q <= SW'(pab3_q[AXIS_X])  + SW'(pab3_q[AXIS_Y])  + SW'(pab3_q[AXIS_Z]);
      vbc4_q <= SW'(pbc3_q[AXIS_X])  + SW'(pbc3_q[AXIS_Y])  + SW'(pbc3_q[AXIS_Z]);
      vca4_q <= SW'(pca3_q[AXIS_X])  + SW'(pca3_q[AXIS_Y])  + SW'(pca3_q[AXIS_Z]);
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: sign tests, every quantity must agree in sign with den or be zero
  // --------------------------------------------------------------------------
  function automatic logic agrees(input logic signed [SW:0] x, input logic sign_pos);
    logic x_neg;
    logic x_zero;
    x_neg  = x[SW];
    x_zero = (x == '0);
    agrees = sign_pos ? !x_neg : (x_neg || x_zero);
  endfunction

  logic              den_pos, den_zero;
  logic signed [SW:0] rem_x;  // den - num, the t <= 1 side
  logic              hit_d, hit_q;

  always_comb begin
    den_zero = (den4_q == '0);
    den_pos  = !den4_q[SW-1] && !den_zero;
    rem_x    = (SW+1)'(den4_q) - (SW+1)'(num4_q);
    hit_d    = !den_zero
            && agrees((SW+1)'(num4_q), den_pos)
            && agrees(rem_x, den_pos)
            && agrees((SW+1)'(vab4_q), den_pos)
            && agrees((SW+1)'(vbc4_q), den_pos)
            && agrees((SW+1)'(vca4_q), den_pos);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4] && valid_q[3]) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // an accepted segment always lands in the first stage
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted segment missing from stage 1");

  // backpressure only reaches the input when every stage is full
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> &valid_q)
    else $error("input stalled with a bubble in the pipeline");

  // a stage blocked by its successor keeps its item
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] && !rdy[3] |=> valid_q[2])
    else $error("stalled item lost in stage 3");

  // a parallel or degenerate case never reports a hit
  a_no_hit_den0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] && rdy[4] && den_zero |=> !hit_o)
    else $error("hit reported with zero denominator");

endmodule

>>> bench/segment_triangle_hit_test_test.sv
// ----------------------------------------------------------------------------
// segment_triangle_hit_test_test
// self-checking bench: segments streamed against configured triangles, each
// hit bit compared in order with an exact integer prediction of the crossing
// ----------------------------------------------------------------------------
module segment_triangle_hit_test_test
  import sth_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW           = 16;
  localparam int unsigned WIDE         = 128;
  localparam int          CLK_PERIOD   = 20;
  localparam int          COORD_MAX    = (1 << (CW - 1)) - 1;
  localparam int          COORD_MIN    = -(1 << (CW - 1));
  localparam int          NUM_VERTICES = 3;
  localparam int          NUM_PHASES   = 6;
  localparam int          ITEMS_PER_PHASE = 138;
  // output back-pressure window, well past the pipeline depth
  localparam int          HOLD_CYCLES  = 64;
  localparam int          HOLD_PHASE   = 4;
  // slack left after the last result before the run ends
  localparam int          DRAIN_CYCLES = 10;
  localparam int          QUIET_LIMIT  = 5000;
  // index with no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNMAPPED = 2'd3;

  typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;
  typedef logic [3*CW-1:0]          vtx_t;
  typedef logic signed [CW-1:0]     coord_t;
  typedef logic signed [WIDE-1:0]   wide_t;

  typedef struct packed {
    wide_t x;
    wide_t y;
    wide_t z;
  } vec_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t sz;
    coord_t ex;
    coord_t ey;
    coord_t ez;
  } seg_t;

  typedef enum logic {ROW_CFG, ROW_SEG} row_kind_e;
  typedef enum logic [1:0] {FROM_MODEL, EXPECT_MISS, EXPECT_HIT} check_e;
  typedef enum logic [1:0] {SPAN_SMALL, SPAN_MEDIUM, SPAN_FULL, SPAN_EXTREME} tri_shape_e;

  typedef struct packed {
    row_kind_e kind;
    cfg_idx_t  index;
    vtx_t      data;
    seg_t      seg;
    check_e    chk;
  } row_t;

  localparam cfg_idx_t VERTEX_REGS [NUM_VERTICES] = '{REG_VERTEX_A, REG_VERTEX_B, REG_VERTEX_C};

  // per phase: triangle size, sender idle percent, receiver idle percent
  localparam tri_shape_e PHASE_SHAPE [NUM_PHASES] =
    '{SPAN_SMALL, SPAN_MEDIUM, SPAN_FULL, SPAN_EXTREME, SPAN_SMALL, SPAN_MEDIUM};
  localparam int SEND_IDLE [NUM_PHASES] = '{20, 20, 79, 79, 0, 0};
  localparam int RECV_IDLE [NUM_PHASES] = '{79, 79, 20, 20, 0, 0};

  // dut signals, the inputs all driven to known values from time zero
  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  cfg_idx_t cfg_index_i = '0;
  vtx_t     cfg_wdata_i = '0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  coord_t   start_x_i   = '0;
  coord_t   start_y_i   = '0;
  coord_t   start_z_i   = '0;
  coord_t   end_x_i     = '0;
  coord_t   end_y_i     = '0;
  coord_t   end_z_i     = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  logic     hit_o;

  // bench state
  vtx_t vertex_regs [NUM_VERTICES] = '{'0, '0, '0};
  bit   pending_hits [$];
  row_t directed_rows [$];
  int   errors        = 0;
  int   quiet_cycles  = 0;
  int   send_idle_pct = 20;
  int   recv_idle_pct = 79;
  logic hold_ask      = 1'b0;
  int   hold_count    = 0;

  segment_triangle_hit_test #(
    .COORD_WIDTH(CW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .start_z_i  (start_z_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .end_z_i    (end_z_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .hit_o      (hit_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ------------------------------------------------------------------
  // exact integer geometry, wide enough that nothing can overflow
  // ------------------------------------------------------------------
  function automatic vec_t vertex(vtx_t r);
    coord_t cx, cy, cz;
    vec_t   v;
    cx = r[CW-1:0];
    cy = r[2*CW-1:CW];
    cz = r[3*CW-1:2*CW];
    v.x = wide_t'(cx);
    v.y = wide_t'(cy);
    v.z = wide_t'(cz);
    return v;
  endfunction

  function automatic vec_t as_vec(coord_t x, coord_t y, coord_t z);
    vec_t v;
    v.x = wide_t'(x);
    v.y = wide_t'(y);
    v.z = wide_t'(z);
    return v;
  endfunction

  function automatic vec_t diff(vec_t p, vec_t q);
    vec_t r;
    r.x = p.x - q.x;
    r.y = p.y - q.y;
    r.z = p.z - q.z;
    return r;
  endfunction

  function automatic vec_t cross_prod(vec_t p, vec_t q);
    vec_t r;
    r.x = p.y * q.z - p.z * q.y;
    r.y = p.z * q.x - p.x * q.z;
    r.z = p.x * q.y - p.y * q.x;
    return r;
  endfunction

  function automatic wide_t dot(vec_t p, vec_t q);
    return p.x * q.x + p.y * q.y + p.z * q.z;
  endfunction

  function automatic int sgn(wide_t w);
    return (w < 0) ? -1 : ((w != 0) ? 1 : 0);
  endfunction

  // plane crossing parameter t = num/den is tested as 0 <= t <= 1 without the
  // division; each edge test is a triple product whose sign carries sign(den)
  function automatic bit segment_hits_triangle(seg_t g);
    vec_t  corner [NUM_VERTICES];
    vec_t  s, d, n;
    wide_t den, num, vol;
    int    sd, i;
    for (i = 0; i < NUM_VERTICES; i++) corner[i] = vertex(vertex_regs[i]);
    s   = as_vec(g.sx, g.sy, g.sz);
    d   = diff(as_vec(g.ex, g.ey, g.ez), s);
    n   = cross_prod(diff(corner[1], corner[0]), diff(corner[2], corner[0]));
    den = dot(d, n);
    num = dot(diff(corner[0], s), n);
    sd  = sgn(den);
    // parallel segment, flat triangle or zero-length segment
    if (sd == 0) return 1'b0;
    // crossing before the start or past the end
    if (sgn(num) * sd < 0 || sgn(den - num) * sd < 0) return 1'b0;
    for (i = 0; i < NUM_VERTICES; i++) begin
      vol = dot(d, cross_prod(diff(corner[i], s), diff(corner[(i + 1) % NUM_VERTICES], s)));
      if (sgn(vol) * sd < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------
  function automatic vtx_t pack_vertex(int x, int y, int z);
    return {coord_t'(z), coord_t'(y), coord_t'(x)};
  endfunction

  function automatic int rand_coord(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic coord_t clamp(int v);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(v);
  endfunction

  function automatic row_t seg_row(int sx, int sy, int sz, int ex, int ey, int ez,
                                   check_e chk);
    row_t row;
    row      = '0;
    row.kind = ROW_SEG;
    row.chk  = chk;
    row.seg  = {coord_t'(sx), coord_t'(sy), coord_t'(sz),
                coord_t'(ex), coord_t'(ey), coord_t'(ez)};
    return row;
  endfunction

  function automatic row_t cfg_row(cfg_idx_t index, vtx_t data);
    row_t row;
    row       = '0;
    row.kind  = ROW_CFG;
    row.index = index;
    row.data  = data;
    row.chk   = FROM_MODEL;
    return row;
  endfunction

  // mostly segments aimed through a blended point of the current triangle,
  // the rest noise: fully random, zero length, or vertex to vertex in-plane
  function automatic seg_t pick_segment();
    int   cx [NUM_VERTICES][3];
    int   w [NUM_VERTICES];
    int   sp [3], ep [3];
    vec_t v;
    seg_t g;
    int   roll, shape, ku, kv, reach, sum, dv, i, ax, p, q;
    for (i = 0; i < NUM_VERTICES; i++) begin
      v = vertex(vertex_regs[i]);
      cx[i][AXIS_X] = int'(v.x);
      cx[i][AXIS_Y] = int'(v.y);
      cx[i][AXIS_Z] = int'(v.z);
    end
    g    = {$urandom, $urandom, $urandom};
    roll = $urandom_range(99);
    if (roll < 65) begin
      sum = 0;
      for (i = 0; i < NUM_VERTICES; i++) begin
        w[i] = $urandom_range(6);
        sum += w[i];
      end
      if (sum == 0) begin
        w[0] = 1;
        sum  = 1;
      end
      reach = 1 << $urandom_range(15);
      shape = $urandom_range(9);
      // shape 0 puts the start on the target point, shape 1 the end
      ku = (shape == 0) ? 0 : $urandom_range(3, 1);
      kv = (shape == 1) ? 0 : $urandom_range(3, 1);
      for (ax = 0; ax < 3; ax++) begin
        p = (w[0] * cx[0][ax] + w[1] * cx[1][ax] + w[2] * cx[2][ax]) / sum;
        dv = int'($urandom_range(2 * reach)) - reach;
        sp[ax] = p - ku * dv;
        ep[ax] = p + kv * dv;
      end
      g = {clamp(sp[AXIS_X]), clamp(sp[AXIS_Y]), clamp(sp[AXIS_Z]),
           clamp(ep[AXIS_X]), clamp(ep[AXIS_Y]), clamp(ep[AXIS_Z])};
    end else if (roll < 85) begin
      // keep the fully random segment
    end else if (roll < 92) begin
      g.ex = g.sx;
      g.ey = g.sy;
      g.ez = g.sz;
    end else begin
      p = $urandom_range(NUM_VERTICES - 1);
      q = $urandom_range(NUM_VERTICES - 1);
      g = {clamp(cx[p][AXIS_X]), clamp(cx[p][AXIS_Y]), clamp(cx[p][AXIS_Z]),
           clamp(cx[q][AXIS_X]), clamp(cx[q][AXIS_Y]), clamp(cx[q][AXIS_Z])};
    end
    return g;
  endfunction

  // ------------------------------------------------------------------
  // drivers, called right after a rising edge
  // ------------------------------------------------------------------
  task automatic send_segment(seg_t g, check_e chk);
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {start_x_i, start_y_i, start_z_i, end_x_i, end_y_i, end_z_i} <= g;
    do @(posedge clk_i); while (!in_ready_o);
    // transaction taken at this edge, configuration is stable while busy
    if (chk == FROM_MODEL) pending_hits.push_back(segment_hits_triangle(g));
    else pending_hits.push_back(chk == EXPECT_HIT);
  endtask

  task automatic write_register(cfg_idx_t index, vtx_t data);
    in_valid_i <= 1'b0;
    // vertices only change with nothing in flight
    while (pending_hits.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index <= REG_VERTEX_C) vertex_regs[index] = data;
  endtask

  // ------------------------------------------------------------------
  // result sink: random idling plus one long hold-off to fill the pipe
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_ask && hold_count < HOLD_CYCLES) begin
      out_ready_i <= 1'b0;
      hold_count  <= hold_count + 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // in-order check of every result transaction
  always @(posedge clk_i) begin : result_check
    bit want_hit;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_hits.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, got hit %0b", $time, hit_o);
      end else begin
        want_hit = pending_hits.pop_front();
        if (hit_o !== want_hit) begin
          errors++;
          $display("%0t ns: hit mismatch, expected %0b, got %0b", $time, want_hit, hit_o);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("segment_triangle_hit_test_test: errors");
    $finish;
  end

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin : main
    int   phase, k, r, ax;
    int   pick [3];
    vtx_t value;

    // after reset the triangle collapses to the origin, so nothing hits
    directed_rows.push_back(seg_row(1, 1, -1, 1, 1, 1, EXPECT_MISS));
    // right triangle in the z = 0 plane
    directed_rows.push_back(cfg_row(REG_VERTEX_A, pack_vertex(0, 0, 0)));
    directed_rows.push_back(cfg_row(REG_VERTEX_B, pack_vertex(100, 0, 0)));
    directed_rows.push_back(cfg_row(REG_VERTEX_C, pack_vertex(0, 100, 0)));
    directed_rows.push_back(seg_row(10, 10, -5, 10, 10, 5, EXPECT_HIT));
    directed_rows.push_back(seg_row(10, 10, 5, 10, 10, -5, EXPECT_HIT));
    // start point, then end point, lying on the face
    directed_rows.push_back(seg_row(10, 10, 0, 10, 10, 5, EXPECT_HIT));
    directed_rows.push_back(seg_row(10, 10, -5, 10, 10, 0, EXPECT_HIT));
    // line crosses the face but beyond either end of the segment
    directed_rows.push_back(seg_row(10, 10, 1, 10, 10, 5, EXPECT_MISS));
    directed_rows.push_back(seg_row(10, 10, -5, 10, 10, -1, EXPECT_MISS));
    // through a vertex, an edge, the hypotenuse, just outside
    directed_rows.push_back(seg_row(0, 0, -1, 0, 0, 1, EXPECT_HIT));
    directed_rows.push_back(seg_row(50, 0, -1, 50, 0, 1, EXPECT_HIT));
    directed_rows.push_back(seg_row(50, 50, -1, 50, 50, 1, EXPECT_HIT));
    directed_rows.push_back(seg_row(51, 50, -1, 51, 50, 1, EXPECT_MISS));
    directed_rows.push_back(seg_row(-1, 10, -1, -1, 10, 1, EXPECT_MISS));
    // parallel in the plane, parallel above it, zero length on the face
    directed_rows.push_back(seg_row(10, 10, 0, 20, 20, 0, EXPECT_MISS));
    directed_rows.push_back(seg_row(10, 10, 3, 50, 20, 3, EXPECT_MISS));
    directed_rows.push_back(seg_row(10, 10, 0, 10, 10, 0, EXPECT_MISS));
    directed_rows.push_back(seg_row(-20, -20, -10, 40, 40, 10, FROM_MODEL));
    directed_rows.push_back(seg_row(COORD_MIN, COORD_MIN, COORD_MIN,
                                    COORD_MAX, COORD_MAX, COORD_MAX, FROM_MODEL));
    directed_rows.push_back(seg_row(COORD_MAX, COORD_MIN, COORD_MAX,
                                    COORD_MIN, COORD_MAX, COORD_MIN, FROM_MODEL));
    // write to the unmapped index leaves the triangle alone
    directed_rows.push_back(cfg_row(REG_UNMAPPED, '1));
    directed_rows.push_back(seg_row(10, 10, -5, 10, 10, 5, EXPECT_HIT));
    // triangle spanning the full coordinate range
    directed_rows.push_back(cfg_row(REG_VERTEX_A, pack_vertex(COORD_MIN, COORD_MIN, 0)));
    directed_rows.push_back(cfg_row(REG_VERTEX_B, pack_vertex(COORD_MAX, COORD_MIN, 0)));
    directed_rows.push_back(cfg_row(REG_VERTEX_C, pack_vertex(COORD_MIN, COORD_MAX, 0)));
    directed_rows.push_back(seg_row(0, 0, COORD_MIN, 0, 0, COORD_MAX, FROM_MODEL));
    directed_rows.push_back(seg_row(COORD_MAX, COORD_MAX, -1, COORD_MAX, COORD_MAX, 1,
                                    FROM_MODEL));
    directed_rows.push_back(seg_row(COORD_MIN, COORD_MIN, COORD_MIN,
                                    COORD_MIN, COORD_MIN, COORD_MAX, FROM_MODEL));
    // third vertex on the first edge: flat triangle
    directed_rows.push_back(cfg_row(REG_VERTEX_C, pack_vertex(0, COORD_MIN, 0)));
    directed_rows.push_back(seg_row(0, COORD_MIN, -1, 0, COORD_MIN, 1, EXPECT_MISS));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_register(directed_rows[i].index, directed_rows[i].data);
      end else begin
        send_segment(directed_rows[i].seg, directed_rows[i].chk);
      end
    end

    // random phases, each with a fresh triangle and its own idling mix
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      for (r = 0; r < NUM_VERTICES; r++) begin
        case (PHASE_SHAPE[phase])
          SPAN_SMALL: begin
            value = pack_vertex(rand_coord(200), rand_coord(200), rand_coord(200));
          end
          SPAN_MEDIUM: begin
            value = pack_vertex(rand_coord(4000), rand_coord(4000), rand_coord(4000));
          end
          SPAN_FULL: begin
            value = vtx_t'({$urandom, $urandom});
          end
          default: begin
            for (ax = 0; ax < 3; ax++) begin
              case ($urandom_range(2))
                0:       pick[ax] = COORD_MIN;
                1:       pick[ax] = 0;
                default: pick[ax] = COORD_MAX;
              endcase
            end
            value = pack_vertex(pick[AXIS_X], pick[AXIS_Y], pick[AXIS_Z]);
          end
        endcase
        write_register(VERTEX_REGS[r], value);
      end
      send_idle_pct = SEND_IDLE[phase];
      recv_idle_pct <= RECV_IDLE[phase];
      // long output stall while the sender keeps pushing
      if (phase == HOLD_PHASE) hold_ask <= 1'b1;
      for (k = 0; k < ITEMS_PER_PHASE; k++) send_segment(pick_segment(), FROM_MODEL);
    end

    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("segment_triangle_hit_test_test: clean");
    end else begin
      $display("segment_triangle_hit_test_test: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sth_pkg.sv
sv/sth_cross.sv
sv/segment_triangle_hit_test.sv
bench/segment_triangle_hit_test_test.sv
